FILE: rtl/periodic_deadline_scheduler_macros.svh
// Assertion macros for the periodic deadline scheduler checker.
// Expects clk and rst to be visible where a macro is used.
`ifndef PERIODIC_DEADLINE_SCHEDULER_MACROS_SVH
`define PERIODIC_DEADLINE_SCHEDULER_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define PDS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define PDS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/pds_pkg.sv
// Shared types and codes for the periodic deadline scheduler.
// No dependencies.
`default_nettype none

package pds_pkg;

  localparam int unsigned DEPTH_DEF = 64;

  // request codes
  localparam logic [1:0] REQ_ADD    = 2'd0;
  localparam logic [1:0] REQ_REMOVE = 2'd1;
  localparam logic [1:0] REQ_TICK   = 2'd2;

  // result status codes
  localparam logic [2:0] ST_ADDED    = 3'd0;
  localparam logic [2:0] ST_REPLACED = 3'd1;
  localparam logic [2:0] ST_REMOVED  = 3'd2;
  localparam logic [2:0] ST_NOTFOUND = 3'd3;
  localparam logic [2:0] ST_FULL     = 3'd4;
  localparam logic [2:0] ST_FIRED    = 3'd5;
  localparam logic [2:0] ST_NOTDUE   = 3'd6;
  localparam logic [2:0] ST_EMPTY    = 3'd7;

  // compare unit operand order
  localparam logic CMP_INS = 1'b0;  // entry deadline < key
  localparam logic CMP_DUE = 1'b1;  // key < entry deadline

  typedef struct packed {
    logic [7:0]  id;
    logic [7:0]  mode;
    logic [31:0] dl;
    logic [31:0] per;
  } entry_t;

  typedef struct packed {
    logic        id_eq;
    logic        lt;
    logic [31:0] sum_sat;
  } cmp_res_t;

endpackage

`default_nettype wire

FILE: rtl/pds_entry_ram.sv
// Entry table storage: one write port, one registered read port.
// Depends on pds_pkg (entry_t).
`default_nettype none

module pds_entry_ram #(
  parameter int unsigned DEPTH = pds_pkg::DEPTH_DEF,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  logic            clk,
  input  logic            we,
  input  logic [AW-1:0]   waddr,
  input  pds_pkg::entry_t wdata,
  input  logic            re,
  input  logic [AW-1:0]   raddr,
  output pds_pkg::entry_t rdata
);
  import pds_pkg::*;

  entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

FILE: rtl/pds_cmp_unit.sv
// Shared compare / add unit working on the entry just read from the table.
// Depends on pds_pkg (entry_t, cmp_res_t, compare op codes).
`default_nettype none

module pds_cmp_unit (
  input  logic              op,
  input  pds_pkg::entry_t   entry,
  input  logic [7:0]        key_id,
  input  logic [31:0]       key_dl,
  output pds_pkg::cmp_res_t res
);
  import pds_pkg::*;

  logic [32:0] sum;

  always_comb begin
    sum         = {1'b0, entry.dl} + {1'b0, entry.per};
    res.id_eq   = (entry.id == key_id);
    res.lt      = (op == CMP_DUE) ? (key_dl < entry.dl) : (entry.dl < key_dl);
    res.sum_sat = sum[32] ? 32'hFFFF_FFFF : sum[31:0];  // saturate on carry
  end

endmodule

`default_nettype wire

FILE: rtl/periodic_deadline_scheduler.sv
// Top level of the periodic deadline scheduler: sequencer, entry RAM, compare unit.
// Depends on pds_pkg, pds_entry_ram, pds_cmp_unit.
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+-----------------------------------------
//  request | in        | in_valid / in_ready  | req_type chan_id test_mode period now_time
//  result  | out       | out_valid / out_ready| status fired_id fired_mode entry_count next_due
//
// Each table walk reads one entry per cycle through the single RAM read port.
// Reset clears the entry count, the sequencer and out_valid; the RAM is not cleared.
// A finished result sits in the output register, so the next request can be
// taken while the result transfer is stalled; in_ready is low while working.
`default_nettype none

module periodic_deadline_scheduler #(
  parameter int unsigned QUEUE_DEPTH = pds_pkg::DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  req_type,
  input  logic [7:0]  chan_id,
  input  logic [7:0]  test_mode,
  input  logic [31:0] period,
  input  logic [31:0] now_time,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  status,
  output logic [7:0]  fired_id,
  output logic [7:0]  fired_mode,
  output logic [6:0]  entry_count,
  output logic [31:0] next_due
);
  import pds_pkg::*;

  localparam int unsigned AW = $clog2(QUEUE_DEPTH);
  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(QUEUE_DEPTH);

  // sequencer states
  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_RMV     = 3'd1;  // find-and-remove walk
  localparam logic [2:0] S_INS     = 3'd2;  // sorted insert walk (bubble carry)
  localparam logic [2:0] S_TICK_RD = 3'd3;
  localparam logic [2:0] S_TICK_WT = 3'd4;
  localparam logic [2:0] S_HEAD_RD = 3'd5;
  localparam logic [2:0] S_HEAD_WT = 3'd6;
  localparam logic [2:0] S_FIN     = 3'd7;

  logic [2:0]    state;
  logic [1:0]    req;
  logic [31:0]   now_q;
  entry_t        carry;      // entry waiting to be written during insert
  logic          found;
  logic          inserted;
  logic          by_head;    // tick: remove the head instead of matching id
  logic [CW-1:0] iss;        // next read index of a walk
  logic          dvld;       // read data of index dtag is valid this cycle
  logic [AW-1:0] dtag;
  logic [CW-1:0] count;
  logic [2:0]    st_code;
  logic [7:0]    fid;
  logic [7:0]    fmode;
  logic [31:0]   ndue;

  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  entry_t        ram_wdata;
  logic          ram_re;
  logic [AW-1:0] ram_raddr;
  entry_t        ram_rdata;
  logic          pass_re;
  logic          pass_done;
  logic          match;
  logic          cmp_op;
  logic [31:0]   cmp_key;
  cmp_res_t      cmp;

  pds_entry_ram #(
    .DEPTH (QUEUE_DEPTH),
    .AW    (AW)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  pds_cmp_unit u_cmp (
    .op     (cmp_op),
    .entry  (ram_rdata),
    .key_id (carry.id),
    .key_dl (cmp_key),
    .res    (cmp)
  );

  assign in_ready = (state == S_IDLE);

  always_comb begin
    pass_re   = 1'b0;
    pass_done = (iss == count) && !dvld;
    ram_re    = 1'b0;
    ram_raddr = iss[AW-1:0];
    ram_we    = 1'b0;
    ram_waddr = dtag;
    ram_wdata = carry;
    cmp_op    = CMP_INS;
    cmp_key   = carry.dl;
    match     = by_head ? (dtag == '0) : cmp.id_eq;
    case (state)
      S_RMV: begin
        pass_re = (iss != count);
        ram_re  = pass_re;
        // once the entry is found, every later entry moves down one slot
        if (dvld && found) begin
          ram_we    = 1'b1;
          ram_waddr = dtag - AW'(1);
          ram_wdata = ram_rdata;
        end
      end
      S_INS: begin
        pass_re = (iss != count);
        ram_re  = pass_re;
        if (dvld && (inserted || !cmp.lt)) begin
          ram_we = 1'b1;
        end else if (pass_done) begin
          // carry lands at the tail
          ram_we    = 1'b1;
          ram_waddr = count[AW-1:0];
        end
      end
      S_TICK_RD, S_HEAD_RD: begin
        ram_re    = (count != '0);
        ram_raddr = '0;
      end
      S_TICK_WT: begin
        cmp_op  = CMP_DUE;
        cmp_key = now_q;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      count     <= '0;
      dvld      <= 1'b0;
      iss       <= '0;
      found     <= 1'b0;
      inserted  <= 1'b0;
      by_head   <= 1'b0;
    end else begin
      // S_FIN reloads the output register itself
      if (out_valid && out_ready && (state != S_FIN)) begin
        out_valid <= 1'b0;
      end
      dvld <= pass_re;
      dtag <= iss[AW-1:0];
      if (pass_re) begin
        iss <= iss + CW'(1);
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            req       <= req_type;
            now_q     <= now_time;
            carry.id  <= chan_id;
            carry.mode <= test_mode;
            carry.dl  <= now_time;
            carry.per <= period;
            fid       <= '0;
            fmode     <= '0;
            found     <= 1'b0;
            inserted  <= 1'b0;
            by_head   <= 1'b0;
            iss       <= '0;
            case (req_type)
              REQ_ADD, REQ_REMOVE: state <= S_RMV;
              REQ_TICK:            state <= S_TICK_RD;
              default: begin
                st_code <= ST_NOTDUE;
                state   <= S_HEAD_RD;
              end
            endcase
          end
        end
        S_RMV: begin
          if (dvld && !found && match) begin
            found <= 1'b1;
          end
          if (pass_done) begin
            iss <= '0;
            if (found) begin
              count <= count - CW'(1);
            end
            case (req)
              REQ_ADD: begin
                if (found) begin
                  st_code <= ST_REPLACED;
                  state   <= S_INS;
                end else if (count == FULL_CNT) begin
                  st_code <= ST_FULL;
                  state   <= S_HEAD_RD;
                end else begin
                  st_code <= ST_ADDED;
                  state   <= S_INS;
                end
              end
              REQ_REMOVE: begin
                st_code <= found ? ST_REMOVED : ST_NOTFOUND;
                state   <= S_HEAD_RD;
              end
              default: state <= S_INS;  // due tick re-inserts the old head
            endcase
          end
        end
        S_INS: begin
          if (dvld && (inserted || !cmp.lt)) begin
            carry    <= ram_rdata;
            inserted <= 1'b1;
          end
          if (pass_done) begin
            count <= count + CW'(1);
            state <= S_HEAD_RD;
          end
        end
        S_TICK_RD: begin
          if (count == '0) begin
            st_code <= ST_EMPTY;
            state   <= S_HEAD_RD;
          end else begin
            state <= S_TICK_WT;
          end
        end
        S_TICK_WT: begin
          if (!cmp.lt) begin
            carry.id   <= ram_rdata.id;
            carry.mode <= ram_rdata.mode;
            carry.dl   <= cmp.sum_sat;
            carry.per  <= ram_rdata.per;
            fid        <= ram_rdata.id;
            fmode      <= ram_rdata.mode;
            st_code    <= ST_FIRED;
            by_head    <= 1'b1;
            iss        <= '0;
            state      <= S_RMV;
          end else begin
            st_code <= ST_NOTDUE;
            state   <= S_HEAD_RD;
          end
        end
        S_HEAD_RD: begin
          if (count == '0) begin
            ndue  <= '0;
            state <= S_FIN;
          end else begin
            state <= S_HEAD_WT;
          end
        end
        S_HEAD_WT: begin
          ndue  <= ram_rdata.dl;
          state <= S_FIN;
        end
        S_FIN: begin
          // wait for the output register to be free
          if (!out_valid || out_ready) begin
            out_valid   <= 1'b1;
            status      <= st_code;
            fired_id    <= fid;
            fired_mode  <= fmode;
            entry_count <= 7'(count);
            next_due    <= ndue;
            state       <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: rtl/pds_checker.sv
// Port-level checker for the periodic deadline scheduler, bound to the top.
// Depends on pds_pkg and periodic_deadline_scheduler_macros.svh.
`default_nettype none
`include "periodic_deadline_scheduler_macros.svh"

module pds_prop_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [2:0]  status,
  input logic [7:0]  fired_id,
  input logic [7:0]  fired_mode,
  input logic [6:0]  entry_count,
  input logic [31:0] next_due
);
  import pds_pkg::*;

  `PDS_ASSERT_IMP(a_rst_idle, $past(rst), !out_valid && in_ready, "not idle after reset")
  `PDS_ASSERT_NXT(a_busy_after_req, in_valid && in_ready, !in_ready, "ready right after a request")
  `PDS_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(status) && $stable(next_due), "stalled result changed")
  `PDS_ASSERT_IMP(a_empty_zero, out_valid && status == ST_EMPTY, entry_count == 7'd0 && next_due == 32'd0, "empty result with entries")
  `PDS_ASSERT_IMP(a_fire_fields, out_valid && status != ST_FIRED, fired_id == 8'd0 && fired_mode == 8'd0, "fired fields set without fire")

endmodule

bind periodic_deadline_scheduler pds_prop_checker u_pds_checker (.*);

`default_nettype wire

FILE: bench/pds_checker.sv
`timescale 1ns / 1ps
// Scoreboard for the periodic deadline scheduler: keeps its own sorted channel table,
// predicts one reply per request transfer and checks reply transfers in order.
// Depends on pds_pkg.
module pds_checker #(
  parameter int DEPTH = pds_pkg::DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [1:0]  req_type,
  input  logic [7:0]  chan_id,
  input  logic [7:0]  test_mode,
  input  logic [31:0] period,
  input  logic [31:0] now_time,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [2:0]  status,
  input  logic [7:0]  fired_id,
  input  logic [7:0]  fired_mode,
  input  logic [6:0]  entry_count,
  input  logic [31:0] next_due,
  output int          fail_count,
  output int          pending,
  output int          checked,
  output int          fired_seen,
  output int          full_seen
);
  import pds_pkg::*;

  typedef struct packed {
    logic [2:0]  status;
    logic [7:0]  id;
    logic [7:0]  mode;
    logic [6:0]  count;
    logic [31:0] due;
  } reply_t;

  entry_t sched [DEPTH];
  int     sched_len;
  reply_t predicted_replies [$];

  function automatic int find_chan(logic [7:0] id);
    for (int i = 0; i < sched_len; i++)
      if (sched[i].id == id) return i;
    return -1;
  endfunction

  function automatic void drop_at(int pos);
    for (int i = pos; i + 1 < sched_len; i++) sched[i] = sched[i + 1];
    sched_len--;
  endfunction

  // earliest deadline first; a new entry goes ahead of equal deadlines
  function automatic void place_sorted(entry_t e);
    int pos = 0;
    while (pos < sched_len && sched[pos].dl < e.dl) pos++;
    for (int i = sched_len; i > pos; i--) sched[i] = sched[i - 1];
    sched[pos] = e;
    sched_len++;
  endfunction

  function automatic reply_t serve_request(logic [1:0] rt, logic [7:0] id, logic [7:0] mode,
                                           logic [31:0] per, logic [31:0] t_now);
    reply_t      r;
    int          pos;
    entry_t      e;
    logic [32:0] sum;
    r = '0;
    r.status = ST_NOTDUE;
    e.id = id;
    e.mode = mode;
    e.dl = t_now;
    e.per = per;
    case (rt)
      REQ_ADD: begin
        pos = find_chan(id);
        if (pos >= 0) begin
          drop_at(pos);
          place_sorted(e);
          r.status = ST_REPLACED;
        end else if (sched_len >= DEPTH) begin
          r.status = ST_FULL;
        end else begin
          place_sorted(e);
          r.status = ST_ADDED;
        end
      end
      REQ_REMOVE: begin
        pos = find_chan(id);
        if (pos >= 0) begin
          drop_at(pos);
          r.status = ST_REMOVED;
        end else begin
          r.status = ST_NOTFOUND;
        end
      end
      REQ_TICK: begin
        if (sched_len == 0) begin
          r.status = ST_EMPTY;
        end else if (t_now >= sched[0].dl) begin
          e = sched[0];
          sum = {1'b0, e.dl} + {1'b0, e.per};
          e.dl = sum[32] ? 32'hFFFF_FFFF : sum[31:0];  // saturate on overflow
          drop_at(0);
          place_sorted(e);
          r.status = ST_FIRED;
          r.id = e.id;
          r.mode = e.mode;
        end
      end
      default: ;  // spare code: no change, reported as not due
    endcase
    r.count = 7'(sched_len);
    r.due = (sched_len > 0) ? sched[0].dl : 32'd0;
    return r;
  endfunction

  task automatic note_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    reply_t want;
    if (rst) begin
      sched_len = 0;
      predicted_replies.delete();
    end else begin
      // reply side first: a reply can never belong to a request taken at this edge
      if (out_valid && out_ready) begin
        if (predicted_replies.size() == 0) begin
          $error("reply transfer with nothing outstanding: status %0d", status);
          fail_count++;
        end else begin
          want = predicted_replies.pop_front();
          checked++;
          if (want.status == ST_FIRED) fired_seen++;
          if (want.status == ST_FULL) full_seen++;
          note_field("status", want.status, status);
          note_field("fired_id", want.id, fired_id);
          note_field("fired_mode", want.mode, fired_mode);
          note_field("entry_count", want.count, entry_count);
          note_field("next_due", want.due, next_due);
        end
      end
      if (in_valid && in_ready)
        predicted_replies.push_back(serve_request(req_type, chan_id, test_mode, period,
                                                  now_time));
    end
    pending = predicted_replies.size();
  end

endmodule

FILE: bench/tb.sv
`timescale 1ns / 1ps
// Top of the scheduler bench: clock, reset, request traffic and reply back-pressure.
// Depends on pds_pkg, periodic_deadline_scheduler and pds_checker.
module tb;
  import pds_pkg::*;

  localparam int DEPTH        = DEPTH_DEF;
  localparam int RANDOM_ITEMS = 700;
  localparam int LIMIT_CYCLES = 1_000_000;
  localparam int HOLD_CYCLES  = 3000;       // long reply stall, forces in_ready low
  localparam int DRAIN_CYCLES = 200;        // longer than the worst request time

  // request code 3 is unused by the block; it must act as a no-op
  localparam logic [1:0] REQ_SPARE = 2'd3;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        out_ready = 1'b0;
  logic [1:0]  req_type = REQ_ADD;
  logic [7:0]  chan_id = '0;
  logic [7:0]  test_mode = '0;
  logic [31:0] period = '0;
  logic [31:0] now_time = '0;

  logic        in_ready;
  logic        out_valid;
  logic [2:0]  status;
  logic [7:0]  fired_id;
  logic [7:0]  fired_mode;
  logic [6:0]  entry_count;
  logic [31:0] next_due;

  int fail_count, pending, checked, fired_seen, full_seen;

  int          requests_sent = 0;  // transfers that the block acts on
  int          spare_sent = 0;     // spare-code transfers, ignored by the block
  int          burst_left = 0;
  int          cycle_count = 0;
  logic [31:0] wall_time = 32'd0;  // running "seconds" used for adds and ticks
  bit          squeeze = 1'b0;     // asks the reply side for its long stall

  always #4 clk = ~clk;

  periodic_deadline_scheduler #(.QUEUE_DEPTH(DEPTH)) dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .req_type(req_type), .chan_id(chan_id), .test_mode(test_mode),
    .period(period), .now_time(now_time),
    .out_valid(out_valid), .out_ready(out_ready),
    .status(status), .fired_id(fired_id), .fired_mode(fired_mode),
    .entry_count(entry_count), .next_due(next_due)
  );

  pds_checker #(.DEPTH(DEPTH)) u_check (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .req_type(req_type), .chan_id(chan_id), .test_mode(test_mode),
    .period(period), .now_time(now_time),
    .out_valid(out_valid), .out_ready(out_ready),
    .status(status), .fired_id(fired_id), .fired_mode(fired_mode),
    .entry_count(entry_count), .next_due(next_due),
    .fail_count(fail_count), .pending(pending), .checked(checked),
    .fired_seen(fired_seen), .full_seen(full_seen)
  );

  // Watchdog: a hung handshake ends the run here.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("Timeout after %0d cycles, %0d replies outstanding", cycle_count, pending);
      $display("Verification failed");
      $finish;
    end
  end

  // One request transfer. Called at a falling edge; returns at a falling edge.
  // Valid stays up between items of a burst; a burst ends with a gap so
  // valid is never dropped and raised in the same step.
  task automatic send_req(logic [1:0] rt, logic [7:0] id, logic [7:0] mode,
                          logic [31:0] per, logic [31:0] t_now);
    in_valid  <= 1'b1;
    req_type  <= rt;
    chan_id   <= id;
    test_mode <= mode;
    period    <= per;
    now_time  <= t_now;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (rt == REQ_SPARE) spare_sent++;
    else requests_sent++;
    @(negedge clk);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 30)) @(negedge clk);
      burst_left = $urandom_range(0, 40);
    end
  endtask

  // Mostly a small id pool so adds collide with live entries and removes hit.
  function automatic logic [7:0] pick_id();
    if ($urandom_range(0, 3) != 0) return 8'($urandom_range(0, 79));
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic logic [31:0] pick_period();
    case ($urandom_range(0, 7))
      0:       return 32'd0;
      1:       return 32'hFFFF_FFFF;
      2:       return $urandom;
      3, 4:    return $urandom_range(0, 1000);
      default: return $urandom_range(1, 40);
    endcase
  endfunction

  // 70 distinct consecutive ids: the table is full after at most 64 of them, so the
  // tail gets refused (or replaces), then one more replace on a full table.
  task automatic fill_table();
    logic [7:0] base;
    base = 8'($urandom_range(0, 255));
    for (int k = 0; k < 70; k++) begin
      send_req(REQ_ADD, base + 8'(k), 8'($urandom), pick_period(), wall_time);
      wall_time += $urandom_range(0, 2);
    end
    send_req(REQ_ADD, base, 8'($urandom), pick_period(), wall_time);
  endtask

  // Mixed adds, removes and ticks with time moving forward.
  task automatic churn(int n);
    int pick;
    repeat (n) begin
      pick = $urandom_range(0, 9);
      if (pick < 4)
        send_req(REQ_ADD, pick_id(), 8'($urandom), pick_period(), wall_time);
      else if (pick < 6)
        send_req(REQ_REMOVE, pick_id(), 8'($urandom), $urandom, $urandom);
      else
        send_req(REQ_TICK, 8'($urandom), 8'($urandom), $urandom, wall_time);
      wall_time += $urandom_range(0, 15);
    end
  endtask

  // Mostly ticks, so due entries keep firing and re-queueing.
  task automatic drain_ticks(int n);
    repeat (n) begin
      if ($urandom_range(0, 7) == 0)
        send_req(REQ_REMOVE, pick_id(), 8'($urandom), $urandom, $urandom);
      else
        send_req(REQ_TICK, 8'($urandom), 8'($urandom), $urandom, wall_time);
      wall_time += $urandom_range(0, 8);
    end
  endtask

  // Remove the whole pool; usually empties the table.
  task automatic sweep_pool();
    for (int k = 0; k < 80; k++)
      send_req(REQ_REMOVE, 8'(k), 8'($urandom), $urandom, $urandom);
  endtask

  // Fully random fields, spare code included.
  task automatic noise(int n);
    repeat (n)
      send_req(2'($urandom_range(0, 3)), 8'($urandom), 8'($urandom), $urandom, $urandom);
  endtask

  // Reply side: segments of always-ready, coin-flip, sparse and mostly-ready
  // back-pressure, plus one long hold-off on request while traffic continues.
  initial begin : reply_sink
    bit squeezed;
    int style;
    int seg_len;
    squeezed = 1'b0;
    forever begin
      if (squeeze && !squeezed) begin
        squeezed = 1'b1;
        repeat (HOLD_CYCLES) begin
          @(negedge clk);
          out_ready <= 1'b0;
        end
      end
      style = $urandom_range(0, 3);
      seg_len = $urandom_range(10, 120);
      repeat (seg_len) begin
        @(negedge clk);
        case (style)
          0:       out_ready <= 1'b1;
          1:       out_ready <= 1'($urandom_range(0, 1));
          2:       out_ready <= ($urandom_range(0, 3) == 0);
          default: out_ready <= ($urandom_range(0, 7) != 0);
        endcase
      end
    end
  end

  initial begin : stimulus
    int directed_count;
    int pick;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    burst_left = $urandom_range(0, 40);

    // Directed: empty table, spare code, ordering on equal deadlines,
    // replace, zero period, deadline saturation, time at its extremes.
    send_req(REQ_TICK,   8'd0,   8'd0,   32'd0,        32'd0);         // tick on empty
    send_req(REQ_REMOVE, 8'd5,   8'd0,   32'd0,        32'd0);         // remove absent id
    send_req(REQ_SPARE,  8'd0,   8'd0,   32'd0,        32'd0);
    send_req(REQ_ADD,    8'd0,   8'd0,   32'd0,        32'd0);
    send_req(REQ_ADD,    8'd255, 8'd255, 32'hFFFF_FFFF, 32'd100);
    send_req(REQ_ADD,    8'd7,   8'hA5,  32'd10,       32'd100);       // ahead of equal dl
    send_req(REQ_ADD,    8'd7,   8'h5A,  32'd20,       32'd50);        // replace, moves up
    send_req(REQ_TICK,   8'd0,   8'd0,   32'd0,        32'd0);         // zero period fire
    send_req(REQ_REMOVE, 8'd0,   8'd0,   32'd0,        32'd0);
    send_req(REQ_TICK,   8'd0,   8'd0,   32'd0,        32'd49);        // one short of due
    send_req(REQ_TICK,   8'd0,   8'd0,   32'd0,        32'd50);        // exactly due
    send_req(REQ_TICK,   8'd0,   8'd0,   32'd0,        32'd100);
    send_req(REQ_TICK,   8'd0,   8'd0,   32'd0,        32'd100);
    send_req(REQ_TICK,   8'd0,   8'd0,   32'd0,        32'd100);       // 255 saturates
    send_req(REQ_TICK,   8'd0,   8'd0,   32'd0,        32'hFFFF_FFFF);
    send_req(REQ_REMOVE, 8'd255, 8'd0,   32'd0,        32'd0);
    send_req(REQ_REMOVE, 8'd255, 8'd0,   32'd0,        32'd0);         // now absent
    send_req(REQ_ADD,    8'd128, 8'hFF,  32'h8000_0000, 32'hFFFF_FFFF);
    send_req(REQ_TICK,   8'hFF,  8'hFF,  32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_req(REQ_SPARE,  8'hFF,  8'hFF,  32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_req(REQ_REMOVE, 8'd7,   8'd0,   32'd0,        32'd0);
    send_req(REQ_REMOVE, 8'd128, 8'd0,   32'd0,        32'd0);
    send_req(REQ_TICK,   8'd0,   8'd0,   32'd0,        32'hFFFF_FFFF); // empty again
    directed_count = requests_sent;

    // Random: first a guaranteed trip to a full table, then weighted scenarios.
    fill_table();
    while (requests_sent < directed_count + RANDOM_ITEMS) begin
      if (!squeeze && requests_sent > directed_count + 300) squeeze = 1'b1;
      pick = $urandom_range(0, 99);
      if (pick < 45)      churn($urandom_range(10, 40));
      else if (pick < 70) drain_ticks($urandom_range(10, 40));
      else if (pick < 80) fill_table();
      else if (pick < 90) noise($urandom_range(3, 12));
      else if (pick < 95) sweep_pool();
      else if ($urandom_range(0, 1) == 0) wall_time = $urandom;
      else wall_time = 32'hFFFF_FF00 + $urandom_range(0, 255);  // near the top
    end
    in_valid <= 1'b0;

    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("Sent %0d requests and %0d spare-code items; %0d replies checked.",
             requests_sent, spare_sent, checked);
    $display("Replies included %0d fired ticks and %0d refusals on a full table.",
             fired_seen, full_seen);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
